[sv/rid_pkg.sv]
// Package for the record identifier parser: status codes, field positions,
// the character classification struct and the checksum letter function.
// Depends on nothing; the classifier, tracker and top-level files import it.
package rid_pkg;

    localparam int unsigned CODE_W    = 16;
    localparam int unsigned ASCII_W   = 7;
    localparam int unsigned POS_W     = 5;
    localparam int unsigned ID_LEN    = 15;
    localparam int unsigned GROUP_LEN = 5;

    localparam logic [POS_W-1:0] POS_INST     = 5'd3;
    localparam logic [POS_W-1:0] POS_RSVD     = 5'd5;
    localparam logic [POS_W-1:0] POS_UID      = 5'd6;
    localparam logic [POS_W-1:0] POS_CKSUM    = 5'd15;
    localparam logic [POS_W-1:0] POS_CKSUM_B  = 5'd16;
    localparam logic [POS_W-1:0] POS_CKSUM_C  = 5'd17;
    localparam logic [POS_W-1:0] POS_TOO_LONG = 5'd18;
    localparam logic [POS_W-1:0] POS_SAT      = 5'd19;

    localparam logic [ASCII_W-1:0] RESERVED_CHAR_RST = 7'd48;

    // ST_OK15 doubles as "no error latched" in the error register.
    typedef enum logic [3:0] {
        ST_OK15           = 4'd0,
        ST_OK18           = 4'd1,
        ST_PREFIX_SHORT   = 4'd2,
        ST_INST_SHORT     = 4'd3,
        ST_RSVD_BAD       = 4'd4,
        ST_UID_SHORT      = 4'd5,
        ST_CKSUM_SHORT    = 4'd6,
        ST_PREFIX_BAD     = 4'd7,
        ST_INST_BAD       = 4'd8,
        ST_UID_BAD        = 4'd9,
        ST_CKSUM_BAD      = 4'd10,
        ST_TOO_LONG       = 4'd11,
        ST_CKSUM_MISMATCH = 4'd12
    } t_status;

    typedef struct packed {
        logic alpha;
        logic upper;
        logic rsvd_match;
    } t_char_class;

    typedef struct packed {
        t_status            status;
        logic [POS_W-1:0]   err_pos;
        logic [ASCII_W-1:0] cc_first;
        logic [ASCII_W-1:0] cc_second;
        logic [ASCII_W-1:0] cc_third;
    } t_result;

    // Five uppercase flags select A-Z for 0-25 and 0-5 for 26-31.
    function automatic logic [ASCII_W-1:0] check_char(input logic [GROUP_LEN-1:0] mask);
        logic [ASCII_W-1:0] wide;
        wide = {2'b00, mask};
        if (mask < 5'd26) begin
            return 7'd65 + wide;
        end else begin
            return 7'd22 + wide;
        end
    endfunction

endpackage

[sv/rid_if.sv]
// Handshake interfaces for the record identifier parser: the character
// channel in and the result channel out. No dependencies.
interface rid_char_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        last;

    modport source (output valid, output code_unit, output last, input ready);
    modport sink   (input valid, input code_unit, input last, output ready);
endinterface

interface rid_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] status;
    logic [4:0] error_position;
    logic [6:0] check_char_first;
    logic [6:0] check_char_second;
    logic [6:0] check_char_third;

    modport source (output valid, output status, output error_position,
                    output check_char_first, output check_char_second,
                    output check_char_third, input ready);
    modport sink   (input valid, input status, input error_position,
                    input check_char_first, input check_char_second,
                    input check_char_third, output ready);
endinterface

[sv/rid_char_class.sv]
// Character classifier: base-62 alphabet, uppercase and reserved match.
// Depends on rid_pkg.
module rid_char_class (
    input  logic [15:0]          i_code_unit,
    input  logic [6:0]           i_reserved_char,
    output rid_pkg::t_char_class o_class
);
    import rid_pkg::*;

    logic w_digit;
    logic w_upper;
    logic w_lower;

    always_comb begin
        w_digit = (i_code_unit >= 16'd48) && (i_code_unit <= 16'd57);
        w_upper = (i_code_unit >= 16'd65) && (i_code_unit <= 16'd90);
        w_lower = (i_code_unit >= 16'd97) && (i_code_unit <= 16'd122);
        o_class.alpha      = w_digit || w_upper || w_lower;
        o_class.upper      = w_upper;
        o_class.rsvd_match = (i_code_unit == {9'd0, i_reserved_char});
    end

endmodule

[sv/rid_track.sv]
// Per-identifier state: position counter, uppercase flags, first-error latch
// and checksum mismatch flag, plus the result formed on the last character.
// Depends on rid_pkg.
module rid_track (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic [15:0]          i_code_unit,
    input  logic                 i_last,
    input  rid_pkg::t_char_class i_class,
    output rid_pkg::t_result     o_result,
    output logic [4:0]           o_char_pos
);
    import rid_pkg::*;

    logic [POS_W-1:0]  r_pos,   n_pos;
    logic [ID_LEN-1:0] r_upper, n_upper;
    t_status           r_kind,  n_kind;
    logic [POS_W-1:0]  r_idx,   n_idx;
    logic              r_mis,   n_mis;

    logic [GROUP_LEN-1:0] w_grp_mask;
    logic [ASCII_W-1:0]   w_expect;

    always_comb begin
        n_upper = r_upper;
        n_kind  = r_kind;
        n_idx   = r_idx;
        n_mis   = r_mis;

        if (r_pos < POS_CKSUM && i_class.upper) begin
            n_upper[r_pos[3:0]] = 1'b1;
        end

        // Checksum character expected at this position, from complete flags.
        case (r_pos)
            POS_CKSUM:   w_grp_mask = r_upper[4:0];
            POS_CKSUM_B: w_grp_mask = r_upper[9:5];
            default:     w_grp_mask = r_upper[14:10];
        endcase
        w_expect = check_char(w_grp_mask);

        if (r_kind == ST_OK15) begin
            if (r_pos >= POS_TOO_LONG) begin
                n_kind = ST_TOO_LONG;
                n_idx  = POS_TOO_LONG;
            end else if (r_pos == POS_RSVD) begin
                if (!i_class.rsvd_match) begin
                    n_kind = ST_RSVD_BAD;
                    n_idx  = POS_RSVD;
                end
            end else if (!i_class.alpha) begin
                if (r_pos < POS_INST) begin
                    n_kind = ST_PREFIX_BAD;
                    n_idx  = r_pos;
                end else if (r_pos < POS_RSVD) begin
                    n_kind = ST_INST_BAD;
                    n_idx  = r_pos - POS_INST;
                end else if (r_pos < POS_CKSUM) begin
                    n_kind = ST_UID_BAD;
                    n_idx  = r_pos - POS_UID;
                end else begin
                    n_kind = ST_CKSUM_BAD;
                    n_idx  = r_pos - POS_CKSUM;
                end
            end else if (r_pos >= POS_CKSUM) begin
                if (i_code_unit != {9'd0, w_expect}) begin
                    n_mis = 1'b1;
                end
            end
        end

        n_pos = (r_pos < POS_SAT) ? r_pos + 5'd1 : r_pos;

        // Result as it stands once this character is counted.
        if (n_kind != ST_OK15) begin
            o_result.status  = n_kind;
            o_result.err_pos = n_idx;
        end else if (n_pos == POS_CKSUM) begin
            o_result.status  = ST_OK15;
            o_result.err_pos = '0;
        end else if (n_pos == POS_TOO_LONG) begin
            if (n_mis) begin
                o_result.status  = ST_CKSUM_MISMATCH;
                o_result.err_pos = POS_CKSUM;
            end else begin
                o_result.status  = ST_OK18;
                o_result.err_pos = '0;
            end
        end else if (n_pos < POS_INST) begin
            o_result.status  = ST_PREFIX_SHORT;
            o_result.err_pos = n_pos;
        end else if (n_pos < POS_RSVD) begin
            o_result.status  = ST_INST_SHORT;
            o_result.err_pos = n_pos - POS_INST;
        end else if (n_pos == POS_RSVD) begin
            o_result.status  = ST_RSVD_BAD;
            o_result.err_pos = POS_RSVD;
        end else if (n_pos < POS_CKSUM) begin
            o_result.status  = ST_UID_SHORT;
            o_result.err_pos = n_pos - POS_UID;
        end else begin
            o_result.status  = ST_CKSUM_SHORT;
            o_result.err_pos = n_pos - POS_CKSUM;
        end

        if (n_pos >= POS_CKSUM) begin
            o_result.cc_first  = check_char(n_upper[4:0]);
            o_result.cc_second = check_char(n_upper[9:5]);
            o_result.cc_third  = check_char(n_upper[14:10]);
        end else begin
            o_result.cc_first  = '0;
            o_result.cc_second = '0;
            o_result.cc_third  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_upper <= '0;
            r_kind  <= ST_OK15;
            r_idx   <= '0;
            r_mis   <= 1'b0;
        end else if (i_adv) begin
            if (i_last) begin
                r_pos   <= '0;
                r_upper <= '0;
                r_kind  <= ST_OK15;
                r_idx   <= '0;
                r_mis   <= 1'b0;
            end else begin
                r_pos   <= n_pos;
                r_upper <= n_upper;
                r_kind  <= n_kind;
                r_idx   <= n_idx;
                r_mis   <= n_mis;
            end
        end
    end

    assign o_char_pos = r_pos;

endmodule

[sv/record_id_parse_and_checksum.sv]
// Record identifier parser and checksum unit. Characters arrive one per
// transfer and one result follows the transfer marked last. The block takes
// a character in every cycle unless the input stalls: a character is held
// in an input register, classified and folded into the identifier state
// when it advances, and a last character's result is registered in the
// output register. The input stalls only when a result is waiting in
// the output register and the sink is not ready. The reserved-character
// register is written through i_cfg_wr_en and i_cfg_wr_data and resets to
// ASCII '0'.
module record_id_parse_and_checksum (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [6:0]  i_cfg_wr_data,
    rid_char_if.sink    i_char,
    rid_result_if.source o_result
);
    import rid_pkg::*;

    logic [ASCII_W-1:0] r_rsvd_char;
    logic               r_in_valid;
    logic [CODE_W-1:0]  r_in_code;
    logic               r_in_last;
    logic               r_out_valid;
    t_result            r_out;

    logic        w_adv;
    t_char_class w_class;
    t_result     w_result;
    logic [4:0]  w_char_pos;

    assign w_adv        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_char.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsvd_char <= RESERVED_CHAR_RST;
        end else if (i_cfg_wr_en) begin
            r_rsvd_char <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_in_code <= i_char.code_unit;
            r_in_last <= i_char.last;
        end
    end

    rid_char_class u_class (
        .i_code_unit     (r_in_code),
        .i_reserved_char (r_rsvd_char),
        .o_class         (w_class)
    );

    rid_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_code_unit (r_in_code),
        .i_last      (r_in_last),
        .i_class     (w_class),
        .o_result    (w_result),
        .o_char_pos  (w_char_pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_last) begin
            r_out <= w_result;
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.status            = r_out.status;
    assign o_result.error_position    = r_out.err_pos;
    assign o_result.check_char_first  = r_out.cc_first;
    assign o_result.check_char_second = r_out.cc_second;
    assign o_result.check_char_third  = r_out.cc_third;

    // The last character of an identifier always restarts the count.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> (w_char_pos == 5'd0))
        else $error("position not cleared after last character");

    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_char_pos <= POS_SAT)
        else $error("character position beyond saturation");

    // A valid identifier carries no error position.
    a_ok_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.status == ST_OK15 || o_result.status == ST_OK18))
        |-> (o_result.error_position == 5'd0))
        else $error("nonzero position on a valid identifier");

    // Checksum letters exist only for identifiers of fifteen or more characters.
    a_cc_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.status == ST_PREFIX_SHORT
            || o_result.status == ST_INST_SHORT || o_result.status == ST_UID_SHORT))
        |-> (o_result.check_char_first == 7'd0 && o_result.check_char_third == 7'd0))
        else $error("checksum letters on a short identifier");

endmodule
